// ===== design/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Op codes, status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // Parameter defaults
  localparam int unsigned CAPACITY_DEF     = 256;
  localparam int unsigned KEY_BITS_DEF     = 32;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned INDEX_W  = 8;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_LOOKUP   = 3'd2,
    OP_READ_POS = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_ISSUE,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT,
    S_POS_CAP,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== design/sorted_key_table.sv =====
// A lookup does a RAM read and a compare per search step; an insert then
//   shifts the entries above the insertion point up one place, and a remove
//   shifts the entries above the removed one down one place.
// A read at position reads one RAM entry unless the position is out of range.
// One request at a time; the next is taken once the result is out.
// Reset clears the entry count and the handshake state, not the RAM.
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key/payload table with binary search
// Entries live in one RAM in ascending key order; a sequencer searches,
// shifts entries up or down and reports status, index, entry and count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table #(
  parameter int unsigned CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS     = skt_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [skt_pkg::OP_W-1:0]          op_i,
  input  wire logic [KEY_BITS-1:0]               key_i,
  input  wire logic [PAYLOAD_BITS-1:0]           payload_i,
  input  wire logic [skt_pkg::POS_W-1:0]         position_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [skt_pkg::STATUS_W-1:0]           status_o,
  output logic [skt_pkg::INDEX_W-1:0]            index_o,
  output logic [KEY_BITS-1:0]                    found_key_o,
  output logic [PAYLOAD_BITS-1:0]                found_payload_o,
  output logic [$clog2(CAPACITY+1)-1:0]          entry_count_o
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > skt_pkg::POS_W) ? CNT_W : skt_pkg::POS_W;
  localparam int unsigned ENT_W  = KEY_BITS + PAYLOAD_BITS;
  localparam logic [CMP_W-1:0] IDX_MAX = CMP_W'((2 ** skt_pkg::INDEX_W) - 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Control state
  skt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             pend_q, pend_d;

  // Request and working registers
  skt_pkg::op_e        op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d, at_q, at_d, rem_q, rem_d;
  logic                hit_q, hit_d, up_q, up_d;
  logic [AW-1:0]       ptr_q, ptr_d, pend_addr_q, pend_addr_d;
  skt_pkg::status_e    res_status_q, res_status_d;
  logic [skt_pkg::INDEX_W-1:0] res_idx_q, res_idx_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;

  // Output registers
  logic [skt_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [skt_pkg::INDEX_W-1:0]  out_idx_q, out_idx_d;
  logic [KEY_BITS-1:0]          out_key_q, out_key_d;
  logic [PAYLOAD_BITS-1:0]      out_pay_q, out_pay_d;
  logic [CNT_W-1:0]             out_cnt_q, out_cnt_d;

  // RAM port signals
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic                    in_accept, out_free, pos_ok;
  logic [CNT_W-1:0]        mid;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [skt_pkg::INDEX_W-1:0] at_sat;

  skt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and helpers
  assign in_stall_o = (state_q != skt_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pos_ok     = CMP_W'(position_i) < CMP_W'(count_q);
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_key     = ram_rdata[ENT_W-1:PAYLOAD_BITS];
  assign rd_pay     = ram_rdata[PAYLOAD_BITS-1:0];
  assign at_sat     = (CMP_W'(at_q) > IDX_MAX) ? skt_pkg::INDEX_W'(IDX_MAX)
                                               : skt_pkg::INDEX_W'(at_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      skt_pkg::S_IDLE: begin
        if (in_accept) begin
          case (skt_pkg::op_e'(op_i))
            skt_pkg::OP_INSERT,
            skt_pkg::OP_REMOVE,
            skt_pkg::OP_LOOKUP:   state_d = skt_pkg::S_SRCH_ISSUE;
            skt_pkg::OP_READ_POS: state_d = pos_ok ? skt_pkg::S_POS_CAP : skt_pkg::S_FINISH;
            default:              state_d = skt_pkg::S_FINISH;
          endcase
        end
      end
      skt_pkg::S_SRCH_ISSUE: begin
        state_d = (lo_q < hi_q) ? skt_pkg::S_SRCH_CMP : skt_pkg::S_DECIDE;
      end
      skt_pkg::S_SRCH_CMP: begin
        state_d = (key_q == rd_key) ? skt_pkg::S_DECIDE : skt_pkg::S_SRCH_ISSUE;
      end
      skt_pkg::S_DECIDE: begin
        case (op_q)
          skt_pkg::OP_INSERT: begin
            state_d = (hit_q || count_q == CAP_CNT) ? skt_pkg::S_FINISH : skt_pkg::S_SHIFT;
          end
          skt_pkg::OP_REMOVE: state_d = hit_q ? skt_pkg::S_SHIFT : skt_pkg::S_FINISH;
          default:            state_d = skt_pkg::S_FINISH;
        endcase
      end
      skt_pkg::S_SHIFT: begin
        if (rem_q == '0 && !pend_q) begin
          state_d = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_POS_CAP: state_d = skt_pkg::S_FINISH;
      skt_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = skt_pkg::S_IDLE;
        end
      end
      default: state_d = skt_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_d      = count_q;
    pend_d       = pend_q;
    op_d         = op_q;
    key_d        = key_q;
    pay_d        = pay_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    at_d         = at_q;
    rem_d        = rem_q;
    hit_d        = hit_q;
    up_d         = up_q;
    ptr_d        = ptr_q;
    pend_addr_d  = pend_addr_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_key_d    = res_key_q;
    res_pay_d    = res_pay_q;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = AW'(mid);

    case (state_q)
      skt_pkg::S_IDLE: begin
        // position read is issued right away; data is used in S_POS_CAP
        ram_raddr = AW'(CMP_W'(position_i));
        if (in_accept) begin
          op_d         = skt_pkg::op_e'(op_i);
          key_d        = key_i;
          pay_d        = payload_i;
          lo_d         = '0;
          hi_d         = count_q;
          at_d         = '0;
          hit_d        = 1'b0;
          res_status_d = skt_pkg::ST_OK;
          res_idx_d    = '0;
          res_key_d    = '0;
          res_pay_d    = '0;
          case (skt_pkg::op_e'(op_i))
            skt_pkg::OP_READ_POS: begin
              res_idx_d    = position_i;
              res_status_d = pos_ok ? skt_pkg::ST_OK : skt_pkg::ST_BAD_POS;
            end
            skt_pkg::OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      skt_pkg::S_SRCH_ISSUE: begin
        if (!(lo_q < hi_q)) begin
          at_d = lo_q;
        end
      end
      skt_pkg::S_SRCH_CMP: begin
        // narrow the window or record the hit
        if (key_q > rd_key) begin
          lo_d = mid + CNT_W'(1);
        end else if (key_q < rd_key) begin
          hi_d = mid;
        end else begin
          hit_d     = 1'b1;
          at_d      = mid;
          res_key_d = rd_key;
          res_pay_d = rd_pay;
        end
      end
      skt_pkg::S_DECIDE: begin
        res_idx_d = at_sat;
        pend_d    = 1'b0;
        case (op_q)
          skt_pkg::OP_INSERT: begin
            if (hit_q) begin
              res_status_d = skt_pkg::ST_DUP;
            end else if (count_q == CAP_CNT) begin
              res_status_d = skt_pkg::ST_FULL;
            end else begin
              res_status_d = skt_pkg::ST_OK;
              res_key_d    = key_q;
              res_pay_d    = pay_q;
              count_d      = count_q + CNT_W'(1);
              up_d         = 1'b1;
              ptr_d        = AW'(count_q - CNT_W'(1));
              rem_d        = count_q - at_q;
            end
          end
          skt_pkg::OP_REMOVE: begin
            if (hit_q) begin
              res_status_d = skt_pkg::ST_OK;
              count_d      = count_q - CNT_W'(1);
              up_d         = 1'b0;
              ptr_d        = AW'(at_q + CNT_W'(1));
              rem_d        = count_q - at_q - CNT_W'(1);
            end else begin
              res_status_d = skt_pkg::ST_NOT_FOUND;
            end
          end
          skt_pkg::OP_LOOKUP: begin
            res_status_d = hit_q ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
          end
          default: ;
        endcase
      end
      skt_pkg::S_SHIFT: begin
        // write back the entry read last cycle, one place over
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = ram_rdata;
        end
        if (rem_q != '0) begin
          ram_raddr   = ptr_q;
          ptr_d       = up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
          pend_addr_d = up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
          rem_d       = rem_q - CNT_W'(1);
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          // shift done: drop the new entry into the gap
          if (!pend_q && up_q) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(at_q);
            ram_wdata = {key_q, pay_q};
          end
        end
      end
      skt_pkg::S_POS_CAP: begin
        res_key_d = rd_key;
        res_pay_d = rd_pay;
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = (state_q == skt_pkg::S_FINISH) || (out_valid_q && out_stall_i);
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_key_d    = out_key_q;
    out_pay_d    = out_pay_q;
    out_cnt_d    = out_cnt_q;
    if (state_q == skt_pkg::S_FINISH && out_free) begin
      out_status_d = res_status_q;
      out_idx_d    = res_idx_q;
      out_key_d    = res_key_q;
      out_pay_d    = res_pay_q;
      out_cnt_d    = count_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    at_q         <= at_d;
    rem_q        <= rem_d;
    hit_q        <= hit_d;
    up_q         <= up_d;
    ptr_q        <= ptr_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_key_q    <= res_key_d;
    res_pay_q    <= res_pay_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_key_q    <= out_key_d;
    out_pay_q    <= out_pay_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign index_o         = out_idx_q;
  assign found_key_o     = out_key_q;
  assign found_payload_o = out_pay_q;
  assign entry_count_o   = out_cnt_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_write_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == skt_pkg::S_SHIFT))
    else $error("RAM write outside shift phase");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skt_pkg::S_SRCH_CMP) |-> (lo_q < hi_q && hi_q <= count_q))
    else $error("search window empty or beyond count");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == skt_pkg::S_FINISH))
    else $error("result beat without finished request");

endmodule

`default_nettype wire

// ===== design/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int unsigned WIDTH = skt_pkg::KEY_BITS_DEF + skt_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned DEPTH = skt_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== test/sorted_key_table_test.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_test: self-checking bench for the sorted key table
// Drives insert, remove, lookup, read-at-position and clear requests with
// random idling on both channels. An in-bench table model predicts every
// result beat, and each beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP      = skt_pkg::CAPACITY_DEF;
  localparam int unsigned KEY_W    = skt_pkg::KEY_BITS_DEF;
  localparam int unsigned PAY_W    = skt_pkg::PAYLOAD_BITS_DEF;
  localparam int unsigned CNT_W    = $clog2(CAP + 1);
  localparam int unsigned OP_W     = skt_pkg::OP_W;
  localparam int unsigned POS_W    = skt_pkg::POS_W;
  localparam int unsigned STATUS_W = skt_pkg::STATUS_W;
  localparam int unsigned INDEX_W  = skt_pkg::INDEX_W;

  // Op codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [PAY_W-1:0] PAY_MAX = '1;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 1000;

  typedef struct {
    skt_pkg::status_e   status;
    logic [INDEX_W-1:0] index;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [CNT_W-1:0]   count;
  } table_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i;
  logic [KEY_W-1:0]     key_i;
  logic [PAY_W-1:0]     payload_i;
  logic [POS_W-1:0]     position_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_o;
  logic [INDEX_W-1:0]   index_o;
  logic [KEY_W-1:0]     found_key_o;
  logic [PAY_W-1:0]     found_payload_o;
  logic [CNT_W-1:0]     entry_count_o;

  // Table model state
  logic [KEY_W-1:0]     model_keys [CAP];
  logic [PAY_W-1:0]     model_pays [CAP];
  int unsigned          model_count;

  table_result_t        pending_results[$];
  int unsigned          requests_sent;
  int unsigned          results_checked;
  int unsigned          mismatch_count;
  int unsigned          cycle_count;
  int unsigned          gap_max;
  int unsigned          stall_max;

  sorted_key_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .key_i          (key_i),
    .payload_i      (payload_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .index_o        (index_o),
    .found_key_o    (found_key_o),
    .found_payload_o(found_payload_o),
    .entry_count_o  (entry_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Binary search over the filled part; at = match or insertion point
  function automatic bit search_table(input logic [KEY_W-1:0] k, output int unsigned at);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = model_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (k > model_keys[mid]) begin
        lo = mid + 1;
      end else if (k < model_keys[mid]) begin
        hi = mid;
      end else begin
        at = mid;
        return 1'b1;
      end
    end
    at = lo;
    return 1'b0;
  endfunction

  // Apply one request to the table model and build the expected beat
  function automatic table_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [PAY_W-1:0] p,
                                                  input logic [POS_W-1:0] pos);
    table_result_t r;
    int unsigned   at;
    int unsigned   i;
    bit            hit;
    r = '{skt_pkg::ST_OK, '0, '0, '0, '0};
    at = 0;
    case (op)
      skt_pkg::OP_INSERT: begin
        hit = search_table(k, at);
        if (hit) begin
          r.status  = skt_pkg::ST_DUP;
          r.key     = model_keys[at];
          r.payload = model_pays[at];
        end else if (model_count >= CAP) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          // shift the upper entries up by one
          for (i = model_count; i > at; i--) begin
            model_keys[i] = model_keys[i-1];
            model_pays[i] = model_pays[i-1];
          end
          model_keys[at] = k;
          model_pays[at] = p;
          model_count++;
          r.key     = k;
          r.payload = p;
        end
      end
      skt_pkg::OP_REMOVE: begin
        hit = search_table(k, at);
        if (hit) begin
          r.key     = model_keys[at];
          r.payload = model_pays[at];
          for (i = at; i + 1 < model_count; i++) begin
            model_keys[i] = model_keys[i+1];
            model_pays[i] = model_pays[i+1];
          end
          model_count--;
        end else begin
          r.status = skt_pkg::ST_NOT_FOUND;
        end
      end
      skt_pkg::OP_LOOKUP: begin
        hit = search_table(k, at);
        if (hit) begin
          r.key     = model_keys[at];
          r.payload = model_pays[at];
        end else begin
          r.status = skt_pkg::ST_NOT_FOUND;
        end
      end
      skt_pkg::OP_READ_POS: begin
        at = pos;
        if (pos < model_count) begin
          r.key     = model_keys[pos];
          r.payload = model_pays[pos];
        end else begin
          r.status = skt_pkg::ST_BAD_POS;
        end
      end
      skt_pkg::OP_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    if (op inside {skt_pkg::OP_INSERT, skt_pkg::OP_REMOVE, skt_pkg::OP_LOOKUP,
                   skt_pkg::OP_READ_POS}) begin
      r.index = (at > 255) ? 8'd255 : 8'(at);
    end
    r.count = CNT_W'(model_count);
    return r;
  endfunction

  // Send one request beat after a random gap; predict on acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= k;
    payload_i  <= p;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_request(op, k, p, pos));
    requests_sent++;
  endtask

  task automatic report_mismatch(input string field, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
    mismatch_count++;
    $display("[%0t] beat %0d: %s expected 0x%0h, got 0x%0h",
             $time, results_checked, field, want, got);
  endtask

  // Result side: random stall, compare each accepted beat
  initial begin
    table_result_t want;
    int unsigned   hold;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat, status", '0, KEY_W'(status_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", KEY_W'(want.status), KEY_W'(status_o));
          if (index_o !== want.index)
            report_mismatch("index", KEY_W'(want.index), KEY_W'(index_o));
          if (found_key_o !== want.key)
            report_mismatch("found_key", want.key, found_key_o);
          if (found_payload_o !== want.payload)
            report_mismatch("found_payload", KEY_W'(want.payload), KEY_W'(found_payload_o));
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", KEY_W'(want.count), KEY_W'(entry_count_o));
        end
        results_checked++;
        hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      end else if (out_valid_o && hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold > 0);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("watchdog expired with %0d beats outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // Empty table, extremes, every op and each corner case
  task automatic test_edge_cases();
    gap_max   = 7;
    stall_max = 7;
    send_request(skt_pkg::OP_LOOKUP, KEY_MAX, '0, '0);
    send_request(skt_pkg::OP_REMOVE, '0, '0, '0);
    send_request(skt_pkg::OP_READ_POS, '0, '0, '0);
    send_request(skt_pkg::OP_INSERT, '0, '0, '0);
    send_request(skt_pkg::OP_INSERT, KEY_MAX, PAY_MAX, '1);
    send_request(skt_pkg::OP_INSERT, 32'h8000_0000, 16'h1234, '0);
    send_request(skt_pkg::OP_INSERT, 32'h8000_0000, 16'h5555, '0);  // duplicate
    send_request(skt_pkg::OP_LOOKUP, KEY_MAX, '0, '0);
    send_request(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, '0, '0);         // miss, middle
    send_request(skt_pkg::OP_READ_POS, '0, PAY_MAX, 8'd0);
    send_request(skt_pkg::OP_READ_POS, KEY_MAX, '0, 8'd2);
    send_request(skt_pkg::OP_READ_POS, '0, '0, 8'd3);                // past the end
    send_request(skt_pkg::OP_READ_POS, '0, '0, '1);
    send_request(skt_pkg::OP_REMOVE, '0, '0, '0);                    // lowest entry
    send_request(skt_pkg::OP_REMOVE, 32'h0000_0001, '0, '0);         // miss
    send_request(skt_pkg::OP_INSERT, 32'h0000_0001, 16'hAAAA, 8'h55);
    send_request(OP_RSVD_A, KEY_MAX, PAY_MAX, '1);
    send_request(OP_RSVD_B, 32'h8000_0000, '0, '0);
    send_request(OP_RSVD_C, '0, '0, '0);
    send_request(skt_pkg::OP_CLEAR, KEY_MAX, PAY_MAX, '1);
    send_request(skt_pkg::OP_READ_POS, '0, '0, '0);
    send_request(skt_pkg::OP_LOOKUP, 32'h8000_0000, '0, '0);
  endtask

  // Fill to capacity, exercise the full-table cases, then clear
  task automatic test_full_table();
    int unsigned n;
    gap_max   = 7;
    stall_max = 7;
    while (model_count < CAP) begin
      send_request(skt_pkg::OP_INSERT, $urandom_range(32'hFFFF_FFFE, 1), 16'($urandom),
                   8'($urandom));
    end
    send_request(skt_pkg::OP_INSERT, KEY_MAX, PAY_MAX, '0);     // full, index saturates
    send_request(skt_pkg::OP_INSERT, '0, '0, '0);               // full, front
    send_request(skt_pkg::OP_INSERT, model_keys[100], '0, '0);  // duplicate wins over full
    send_request(skt_pkg::OP_LOOKUP, model_keys[CAP-1], '0, '0);
    send_request(skt_pkg::OP_LOOKUP, KEY_MAX, '0, '0);          // miss past the end
    send_request(skt_pkg::OP_READ_POS, '0, '0, '1);
    send_request(skt_pkg::OP_REMOVE, model_keys[0], '0, '0);    // longest shift down
    send_request(skt_pkg::OP_INSERT, KEY_MAX, PAY_MAX, '0);
    send_request(skt_pkg::OP_LOOKUP, KEY_MAX, '0, '0);
    send_request(skt_pkg::OP_REMOVE, KEY_MAX, '0, '0);
    send_request(skt_pkg::OP_INSERT, '0, 16'h0F0F, '0);         // longest shift up
    for (n = 0; n < 20; n++) begin
      send_request(skt_pkg::OP_READ_POS, 32'($urandom), '0, 8'($urandom));
    end
    send_request(skt_pkg::OP_CLEAR, '0, '0, '0);
    send_request(skt_pkg::OP_READ_POS, '0, '0, '0);
  endtask

  // Key mix: mostly stored keys and a small range, so hits and dups are common
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = (model_count > 0) ? model_keys[$urandom_range(0, model_count - 1)]
                                        : 32'($urandom);
      4, 5:       k = $urandom_range(0, 47);
      6:          k = $urandom_range(0, 1) ? KEY_MAX : '0;
      default:    k = $urandom;
    endcase
    return k;
  endfunction

  // Random traffic with idling on both sides
  task automatic test_random_traffic();
    int unsigned      n;
    int unsigned      roll;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    gap_max   = 7;
    stall_max = 7;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        op = (model_count > 160 && roll < 20) ? skt_pkg::OP_REMOVE : skt_pkg::OP_INSERT;
      else if (roll < 65) op = skt_pkg::OP_REMOVE;
      else if (roll < 82) op = skt_pkg::OP_LOOKUP;
      else if (roll < 94) op = skt_pkg::OP_READ_POS;
      else if (roll < 96) op = skt_pkg::OP_CLEAR;
      else                op = OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
      if (model_count > 0 && $urandom_range(0, 3) != 0)
        pos = POS_W'($urandom_range(0, model_count - 1));
      else
        pos = POS_W'($urandom);
      send_request(op, pick_key(), 16'($urandom), pos);
    end
  endtask

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = '0;
    key_i           = '0;
    payload_i       = '0;
    position_i      = '0;
    model_count     = 0;
    requests_sent   = 0;
    results_checked = 0;
    mismatch_count  = 0;
    gap_max         = 0;
    stall_max       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_full_table();
    test_random_traffic();
    in_valid_i <= 1'b0;

    // drain, then watch for stray beats
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests and %0d result beats: edge cases, a full table, random traffic",
             requests_sent, results_checked);
    $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/skt_pkg.sv
design/skt_ram.sv
design/sorted_key_table.sv
test/sorted_key_table_test.sv
